/* hw/rtl/gb3_pkg.sv */
package gb3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_CHANNELS = 4;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 16;
    localparam int CHAN_W       = 3;
    localparam int PIX_W        = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W    = OUT_PTR_W + 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 16'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [CHAN_W-1:0]   CHAN_MAX     = CHAN_W'(MAX_CHANNELS);
    localparam logic [CHAN_W-1:0]   CHAN_RESET   = 3'd1;

    typedef struct packed {
        logic       kind;
        logic [7:0] sample_ch0;
        logic [7:0] sample_ch1;
        logic [7:0] sample_ch2;
        logic [7:0] sample_ch3;
    } in_item_t;

    typedef struct packed {
        logic [7:0] blurred_ch0;
        logic [7:0] blurred_ch1;
        logic [7:0] blurred_ch2;
        logic [7:0] blurred_ch3;
        logic       frame_end;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic             emit;
        logic             first_col;
        logic             last_col;
        logic             top_edge;
        logic             bottom_edge;
        logic             frame_end;
        logic [COL_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } tag_t;

endpackage

/* hw/rtl/gb3_ram.sv */
module gb3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/gb3_ctrl.sv */
module gb3_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  gb3_pkg::in_item_t                in_data,
    input  logic [gb3_pkg::OUT_CNT_W-1:0]    out_count,
    output logic [gb3_pkg::COL_W-1:0]        rd_col,
    output logic [gb3_pkg::CHAN_W-1:0]       chan_count,
    output gb3_pkg::tag_t                    tag
);
    import gb3_pkg::*;

    logic [WIDTH_W-1:0]  width_reg,   width_next;
    logic [HEIGHT_W-1:0] height_reg,  height_next;
    logic [CHAN_W-1:0]   chan_reg,    chan_next;
    logic [COL_W-1:0]    in_col_reg,  in_col_next;
    logic [HEIGHT_W-1:0] in_row_reg,  in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic                tag_valid_reg;
    tag_t                tag_reg, tag_next;

    logic                draining;
    logic                take;
    logic                accept;
    logic                col_wrap;
    logic                out_col_wrap;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;
    logic [CHAN_W-1:0]   cfg_chan;
    logic [OUT_CNT_W:0]  pending;

    // results already queued plus the one in flight
    assign pending  = {1'b0, out_count} + (OUT_CNT_W+1)'(tag_valid_reg && tag_reg.emit);
    assign in_ready = pending < (OUT_CNT_W+1)'(OUT_DEPTH);
    assign accept   = in_valid && in_ready;

    assign draining = in_row_reg >= height_reg;
    assign take     = (in_data.kind == KIND_PIXEL) ? !draining : draining;
    assign col_wrap = ({1'b0, in_col_reg} + 1'b1) >= width_reg;
    assign out_col_wrap = ({1'b0, out_col_reg} + 1'b1) >= width_reg;

    always_comb
    begin
        cfg_width = cfg_data[WIDTH_W-1:0];
        if (cfg_width < WIDTH_MIN)
        begin
            cfg_width = WIDTH_MIN;
        end
        else if (cfg_width > WIDTH_MAX)
        begin
            cfg_width = WIDTH_MAX;
        end
        cfg_height = cfg_data[HEIGHT_W-1:0];
        if (cfg_height < HEIGHT_MIN)
        begin
            cfg_height = HEIGHT_MIN;
        end
        cfg_chan = cfg_data[CHAN_W-1:0];
        if (cfg_chan == '0)
        begin
            cfg_chan = CHAN_W'(1);
        end
        else if (cfg_chan > CHAN_MAX)
        begin
            cfg_chan = CHAN_MAX;
        end
    end

    always_comb
    begin
        tag_next.emit        = (in_row_reg >= HEIGHT_W'(2))
                             || (in_row_reg == HEIGHT_W'(1) && in_col_reg != '0);
        tag_next.first_col   = out_col_reg == '0;
        tag_next.last_col    = out_col_wrap;
        tag_next.top_edge    = out_row_reg == '0;
        tag_next.bottom_edge = ({1'b0, out_row_reg} + 1'b1) >= {1'b0, height_reg};
        tag_next.frame_end   = tag_next.emit && out_col_wrap && tag_next.bottom_edge;
        tag_next.col         = in_col_reg;
        tag_next.pixel       = (in_data.kind == KIND_PIXEL)
                             ? {in_data.sample_ch3, in_data.sample_ch2,
                                in_data.sample_ch1, in_data.sample_ch0}
                             : '0;
        tag_next.valid       = accept && take;

        width_next   = width_reg;
        height_next  = height_reg;
        chan_next    = chan_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT
                       || cfg_index == CFG_CHANNEL_COUNT))
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  width_next  = cfg_width;
                CFG_FRAME_HEIGHT: height_next = cfg_height;
                default:          chan_next   = cfg_chan;
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept && take)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                if (in_row_reg < height_reg)
                begin
                    in_row_next = in_row_reg + 1'b1;
                end
            end
            else
            begin
                in_col_next = in_col_reg + 1'b1;
            end
            if (tag_next.emit)
            begin
                if (tag_next.frame_end)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            chan_reg      <= CHAN_RESET;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            chan_reg      <= chan_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            tag_valid_reg <= tag_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg <= tag_next;
    end

    always_comb
    begin
        tag       = tag_reg;
        tag.valid = tag_valid_reg;
    end

    assign rd_col     = in_col_reg;
    assign chan_count = chan_reg;

endmodule

/* hw/rtl/gb3_window.sv */
module gb3_window (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gb3_pkg::tag_t                tag,
    input  logic [gb3_pkg::PIX_W-1:0]    rd_upper,
    input  logic [gb3_pkg::PIX_W-1:0]    rd_middle,
    input  logic [gb3_pkg::CHAN_W-1:0]   chan_count,
    output logic                         wr_en,
    output logic [gb3_pkg::COL_W-1:0]    wr_col,
    output logic [gb3_pkg::PIX_W-1:0]    wr_upper,
    output logic [gb3_pkg::PIX_W-1:0]    wr_middle,
    output logic                         res_valid,
    output gb3_pkg::out_item_t           res
);
    import gb3_pkg::*;

    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] new_col  [3];
    // taps[k][r]: left, center, right column, top to bottom
    logic [PIX_W-1:0] taps     [3][3];
    logic [7:0]       blurred  [4];
    logic [7:0]       t_pix;
    logic [7:0]       m_pix;
    logic [7:0]       b_pix;
    logic [9:0]       col_sum  [3];
    logic [11:0]      sum;

    assign new_col[0] = rd_upper;
    assign new_col[1] = rd_middle;
    assign new_col[2] = tag.pixel;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3]     = win_reg[r*3+1];
            win_next[r*3+1]   = win_reg[r*3+2];
            win_next[r*3+2]   = new_col[r];
            taps[0][r] = (tag.first_col && !tag.last_col) ? win_reg[r*3+2] : win_reg[r*3+1];
            taps[1][r] = win_reg[r*3+2];
            taps[2][r] = tag.last_col ? win_reg[r*3+2] : new_col[r];
        end
    end

    always_comb
    begin
        t_pix = '0;
        m_pix = '0;
        b_pix = '0;
        sum   = '0;
        for (int k = 0; k < 3; k++)
        begin
            col_sum[k] = '0;
        end
        for (int ch = 0; ch < 4; ch++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                m_pix = taps[k][1][ch*8 +: 8];
                t_pix = tag.top_edge    ? m_pix : taps[k][0][ch*8 +: 8];
                b_pix = tag.bottom_edge ? m_pix : taps[k][2][ch*8 +: 8];
                col_sum[k] = 10'(t_pix) + {1'b0, m_pix, 1'b0} + 10'(b_pix);
            end
            sum = 12'(col_sum[0]) + {1'b0, col_sum[1], 1'b0} + 12'(col_sum[2]);
            blurred[ch] = (CHAN_W'(ch) < chan_count) ? sum[11:4] : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (tag.valid)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign wr_en     = tag.valid;
    assign wr_col    = tag.col;
    assign wr_upper  = rd_middle;
    assign wr_middle = tag.pixel;

    assign res_valid       = tag.valid && tag.emit;
    assign res.blurred_ch0 = blurred[0];
    assign res.blurred_ch1 = blurred[1];
    assign res.blurred_ch2 = blurred[2];
    assign res.blurred_ch3 = blurred[3];
    assign res.frame_end   = tag.frame_end;

endmodule

/* hw/rtl/gb3_out_fifo.sv */
module gb3_out_fifo (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  gb3_pkg::out_item_t            push_item,
    output logic                          out_valid,
    input  logic                          out_ready,
    output gb3_pkg::out_item_t            out_data,
    output logic [gb3_pkg::OUT_CNT_W-1:0] count
);
    import gb3_pkg::*;

    out_item_t            buf_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg,  count_next;
    logic                 pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign out_data  = buf_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* hw/rtl/gaussian_blur_3x3_stream_core.sv */
// 3x3 gaussian blur (1-2-1 kernel, divided by 16) over a raster pixel stream.
// in_valid/in_ready/in_data: one pixel item per handshake, up to four 8-bit
// channels; kind = drain marks a flush tick sent after the last pixel.
// out_valid/out_ready/out_data: one blurred pixel per handshake, frame_end
// set on the last pixel of the frame; unused channels read zero.
// cfg_we/cfg_index/cfg_data: register write, 0 = frame width, 1 = frame
// height, 2 = channel count; write only while idle, a write restarts the frame.
// The blurred pixel for input n leaves with input n + width + 1, so width + 1
// drain ticks follow each frame; edges replicate the border pixels.
// Throughput: one item per clock while in_ready is high, set by the line store
// ports (one read and one write per store each cycle). An accepted item passes
// the tag register and then the output queue before its result shows.
// A four-entry output queue absorbs receiver stalls; in_ready drops once the
// queue plus the item in flight could fill it, and nothing is lost.
// Reset: counters clear, width 640, height 480, one channel; the line stores
// are not cleared, and the first rows never use their old contents.
module gaussian_blur_3x3_stream_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  gb3_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output gb3_pkg::out_item_t              out_data
);
    import gb3_pkg::*;

    tag_t             tag;
    logic [COL_W-1:0] rd_col;
    logic [CHAN_W-1:0] chan_count;
    logic [OUT_CNT_W-1:0] out_count;
    logic [PIX_W-1:0] rd_upper;
    logic [PIX_W-1:0] rd_middle;
    logic             wr_en;
    logic [COL_W-1:0] wr_col;
    logic [PIX_W-1:0] wr_upper;
    logic [PIX_W-1:0] wr_middle;
    logic             res_valid;
    out_item_t        res;

    gb3_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_count  (out_count),
        .rd_col     (rd_col),
        .chan_count (chan_count),
        .tag        (tag)
    );

    gb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_col),
        .wdata (wr_upper),
        .raddr (rd_col),
        .rdata (rd_upper)
    );

    gb3_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_col),
        .wdata (wr_middle),
        .raddr (rd_col),
        .rdata (rd_middle)
    );

    gb3_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .tag        (tag),
        .rd_upper   (rd_upper),
        .rd_middle  (rd_middle),
        .chan_count (chan_count),
        .wr_en      (wr_en),
        .wr_col     (wr_col),
        .wr_upper   (wr_upper),
        .wr_middle  (wr_middle),
        .res_valid  (res_valid),
        .res        (res)
    );

    gb3_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .count     (out_count)
    );

endmodule

/* tb/sv/gaussian_blur_3x3_stream_checker.sv */
`timescale 1ns / 100ps

module gaussian_blur_3x3_stream_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gb3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  gb3_pkg::in_item_t               in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  gb3_pkg::out_item_t              out_data,
    output int                              mismatch_count,
    output int                              pending_count
);

    import gb3_pkg::*;

    logic [PIX_W-1:0]    upper_rows [MAX_WIDTH];
    logic [PIX_W-1:0]    middle_rows [MAX_WIDTH];
    logic [PIX_W-1:0]    window_px [9];
    int                  in_col;
    int                  in_row;
    int                  out_col;
    int                  out_row;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHAN_W-1:0]   chan_reg;

    out_item_t           expected_pixels [$];
    out_item_t           want;
    bit                  produced;
    int                  errors;
    int                  i;

    task automatic clear_counters();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endtask

    // one blurred pixel from the window, columns lc/cc/rc as left/center/right
    function automatic out_item_t blur_window(input int lc, input int cc, input int rc,
                                              input bit top_edge, input bit bottom_edge,
                                              input int nch);
        int               ch;
        int               k;
        int               sel;
        int               sum;
        int               tv;
        int               mv;
        int               bv;
        logic [PIX_W-1:0] levels;
        out_item_t        res;
        levels = '0;
        for (ch = 0; ch < 4; ch++)
        begin
            sum = 0;
            if (ch < nch)
            begin
                for (k = 0; k < 3; k++)
                begin
                    sel = (k == 0) ? lc : (k == 1) ? cc : rc;
                    tv  = window_px[sel][ch*8 +: 8];
                    mv  = window_px[3 + sel][ch*8 +: 8];
                    bv  = window_px[6 + sel][ch*8 +: 8];
                    if (top_edge)
                        tv = mv;
                    if (bottom_edge)
                        bv = mv;
                    sum += ((k == 1) ? 2 : 1) * (tv + 2 * mv + bv);
                end
            end
            levels[ch*8 +: 8] = 8'(sum >> 4);
        end
        res             = '0;
        res.blurred_ch0 = levels[7:0];
        res.blurred_ch1 = levels[15:8];
        res.blurred_ch2 = levels[23:16];
        res.blurred_ch3 = levels[31:24];
        return res;
    endfunction

    task automatic predict_blur(input in_item_t item, output bit emit, output out_item_t result);
        int               w;
        int               h;
        int               nch;
        int               col;
        int               oc;
        int               orow;
        int               r;
        bit               draining;
        bit               last_col;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        w = width_reg;
        if (w < WIDTH_MIN)
            w = WIDTH_MIN;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h        = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
        nch      = (chan_reg == 0) ? 1 : (chan_reg > CHAN_MAX) ? MAX_CHANNELS : chan_reg;
        draining = (in_row >= h);
        emit     = 1'b0;
        result   = '0;
        // pixels after the frame is complete and early drain ticks do nothing
        if ((item.kind == KIND_DRAIN) == draining)
        begin
            if (item.kind == KIND_PIXEL)
                px = {item.sample_ch3, item.sample_ch2, item.sample_ch1, item.sample_ch0};
            else
                px = '0;
            col = (in_col >= w) ? 0 : in_col;
            up  = upper_rows[col];
            mid = middle_rows[col];
            upper_rows[col]  = mid;
            middle_rows[col] = px;

            emit     = (in_row >= 2) || (in_row == 1 && col >= 1);
            oc       = out_col;
            orow     = out_row;
            last_col = emit && (oc + 1 >= w);

            if (last_col)
                result = blur_window(1, 2, 2, orow == 0, orow + 1 >= h, nch);
            for (r = 0; r < 3; r++)
            begin
                window_px[r*3]     = window_px[r*3 + 1];
                window_px[r*3 + 1] = window_px[r*3 + 2];
            end
            window_px[2] = up;
            window_px[5] = mid;
            window_px[8] = px;
            if (emit && !last_col)
                result = blur_window((oc == 0) ? 1 : 0, 1, 2, orow == 0, orow + 1 >= h, nch);

            in_col = col + 1;
            if (in_col >= w)
            begin
                in_col = 0;
                if (in_row < h)
                    in_row++;
            end

            if (emit)
            begin
                result.frame_end = last_col && (orow + 1 >= h);
                if (result.frame_end)
                    clear_counters();
                else
                begin
                    out_col = oc + 1;
                    if (out_col >= w)
                    begin
                        out_col = 0;
                        out_row = orow + 1;
                    end
                end
            end
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            errors++;
            $error("%s: expected %0d, got %0d", field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (i = 0; i < MAX_WIDTH; i++)
            begin
                upper_rows[i]  = '0;
                middle_rows[i] = '0;
            end
            for (i = 0; i < 9; i++)
                window_px[i] = '0;
            clear_counters();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            chan_reg   = CHAN_RESET;
            expected_pixels.delete();
            errors = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    $error("output item with no expected result: frame_end %0d",
                           out_data.frame_end);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("blurred_ch0", want.blurred_ch0, out_data.blurred_ch0);
                    compare_field("blurred_ch1", want.blurred_ch1, out_data.blurred_ch1);
                    compare_field("blurred_ch2", want.blurred_ch2, out_data.blurred_ch2);
                    compare_field("blurred_ch3", want.blurred_ch3, out_data.blurred_ch3);
                    compare_field("frame_end", {7'd0, want.frame_end},
                                  {7'd0, out_data.frame_end});
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:
                    begin
                        width_reg = cfg_data[WIDTH_W-1:0];
                        clear_counters();
                    end
                    CFG_FRAME_HEIGHT:
                    begin
                        height_reg = cfg_data[HEIGHT_W-1:0];
                        clear_counters();
                    end
                    CFG_CHANNEL_COUNT:
                    begin
                        chan_reg = cfg_data[CHAN_W-1:0];
                        clear_counters();
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (in_valid && in_ready)
            begin
                predict_blur(in_data, produced, want);
                if (produced)
                    expected_pixels.push_back(want);
            end

            mismatch_count <= errors;
            pending_count  <= expected_pixels.size();
        end
    end

endmodule

/* tb/sv/gaussian_blur_3x3_stream_core_tb.sv */
`timescale 1ns / 100ps

module gaussian_blur_3x3_stream_core_tb;

    import gb3_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
    localparam int FILL_RANDOM    = 0;
    localparam int FILL_EXTREME   = 1;
    localparam int RANDOM_ITEMS   = 220;
    localparam int PARTIAL_ITEMS  = 24;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;

    int mismatches;
    int pending;
    int frame_w;
    int frame_h;
    int quiet_cycles;
    bit fast_in;
    bit fast_out;

    gaussian_blur_3x3_stream_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    gaussian_blur_3x3_stream_checker blur_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .mismatch_count (mismatches),
        .pending_count  (pending)
    );

    always #10 clk = ~clk;

    task automatic send_item(input in_item_t item);
        int gap;
        gap = fast_in ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic in_item_t pixel_item(input int fill, input int idx);
        in_item_t item;
        item.kind = KIND_PIXEL;
        if (fill == FILL_EXTREME)
        begin
            item.sample_ch0 = idx[0] ? 8'hFF : 8'h00;
            item.sample_ch1 = ~item.sample_ch0;
            item.sample_ch2 = (idx % 3 == 0) ? 8'hFF : 8'h00;
            item.sample_ch3 = idx[1] ? 8'h00 : 8'hFF;
        end
        else
        begin
            item.sample_ch0 = 8'($urandom);
            item.sample_ch1 = 8'($urandom);
            item.sample_ch2 = 8'($urandom);
            item.sample_ch3 = 8'($urandom);
        end
        return item;
    endfunction

    function automatic in_item_t drain_item();
        in_item_t item;
        item            = pixel_item(FILL_RANDOM, 0);
        item.kind       = KIND_DRAIN;
        return item;
    endfunction

    // full frame when rows equals the height, else an abandoned partial frame
    task automatic run_frame(input int rows, input int fill, input bit noisy);
        int total;
        int early_at;
        int stray_at;
        int n;
        total    = frame_w * rows;
        early_at = noisy ? $urandom_range(0, total) : -1;
        stray_at = noisy ? $urandom_range(0, frame_w) : -1;
        fast_in  = ($urandom_range(0, 3) == 0);
        for (n = 0; n < total; n++)
        begin
            if (n == early_at)
                send_item(drain_item());
            send_item(pixel_item(fill, n));
        end
        if (rows == frame_h)
        begin
            for (n = 0; n <= frame_w; n++)
            begin
                if (n == stray_at)
                    send_item(pixel_item(FILL_RANDOM, n));
                send_item(drain_item());
            end
            if (noisy)
                send_item(drain_item());
        end
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] width_val,
                             input logic [CFG_DATA_W-1:0] height_val,
                             input logic [CFG_DATA_W-1:0] chan_val,
                             input bit poke_unmapped);
        settle_idle();
        if (poke_unmapped)
            write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        write_reg(CFG_FRAME_WIDTH, width_val);
        write_reg(CFG_FRAME_HEIGHT, height_val);
        write_reg(CFG_CHANNEL_COUNT, chan_val);
        cfg_we <= 1'b0;
        frame_w = width_val[WIDTH_W-1:0];
        if (frame_w < WIDTH_MIN)
            frame_w = WIDTH_MIN;
        if (frame_w > WIDTH_MAX)
            frame_w = WIDTH_MAX;
        frame_h = (height_val < HEIGHT_MIN) ? HEIGHT_MIN : height_val;
    endtask

    // result side: random stall before each item, with stretches of none
    initial
    begin
        fast_out = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            int stall;
            stall = fast_out ? 0 : $urandom_range(0, 12);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if ($urandom_range(0, 39) == 0)
                fast_out = !fast_out;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int  random_pixels;
        int  rows;
        int  n;
        bit  need_config;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        fast_in   = 1'b0;
        frame_w   = WIDTH_RESET;
        frame_h   = HEIGHT_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: the start of a 640-wide frame, then abandoned
        for (n = 0; n < PARTIAL_ITEMS; n++)
            send_item(pixel_item(FILL_RANDOM, n));

        // smallest frame, all channels, extreme samples, stray items
        configure(WIDTH_MIN, HEIGHT_MIN, CHAN_MAX, 1'b1);
        run_frame(frame_h, FILL_EXTREME, 1'b1);

        // out of range settings clamp
        configure(16'h0000, 16'h0000, 16'h0000, 1'b0);
        run_frame(frame_h, FILL_RANDOM, 1'b1);
        configure(16'h0002, 16'h0002, 16'h0005, 1'b0);
        run_frame(frame_h, FILL_RANDOM, 1'b0);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        for (n = 0; n < PARTIAL_ITEMS; n++)
            send_item(pixel_item(FILL_RANDOM, n));
        configure(16'd8, HEIGHT_MIN, 16'd2, 1'b0);
        run_frame(frame_h, FILL_RANDOM, 1'b1);

        random_pixels = 0;
        need_config   = 1'b1;
        while (random_pixels < RANDOM_ITEMS)
        begin
            if (need_config || $urandom_range(0, 2) == 0)
                configure(CFG_DATA_W'(($urandom & 16'hF800) |
                          (($urandom_range(0, 7) == 0) ? $urandom_range(0, 64)
                                                       : $urandom_range(3, 12))),
                          CFG_DATA_W'($urandom_range(0, 6)),
                          CFG_DATA_W'(($urandom & 16'hFFF8) | $urandom_range(0, 7)),
                          $urandom_range(0, 9) == 0);
            rows = ($urandom_range(0, 4) == 0) ? $urandom_range(0, frame_h - 1) : frame_h;
            need_config = (rows < frame_h);
            run_frame(rows, FILL_RANDOM, $urandom_range(0, 2) == 0);
            random_pixels += frame_w * rows;
        end

        settle_idle();
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
